@@ design/elfsv_pkg.sv @@
// elfsv_pkg.sv: shared types and constants of the elf64 segment validator
`timescale 1ns / 1ps

package elfsv_pkg;

  localparam logic [31:0] PT_LOADABLE = 32'd1;
  localparam int unsigned FLAG_EXEC_BIT = 0;

  localparam logic [21:0] IMG_LEN_RST = 22'd0;
  localparam logic [63:0] ENTRY_POINT_RST = 64'd0;
  localparam logic [63:0] PHYS_BASE_RST = 64'h0000_0000_0040_0000;
  localparam logic [31:0] WINDOW_SIZE_RST = 32'h0040_0000;
  localparam logic [63:0] DIRECT_BASE_RST = 64'hffff_f800_0000_0000;

  typedef enum logic [2:0] {
    CFG_IMG_LEN     = 3'd0,
    CFG_ENTRY_POINT = 3'd1,
    CFG_PHYS_BASE   = 3'd2,
    CFG_WINDOW_SIZE = 3'd3,
    CFG_DIRECT_BASE = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STAT_SKIP    = 3'd0,
    STAT_OK      = 3'd1,
    STAT_CHECK   = 3'd2,
    STAT_OVERLAP = 3'd3,
    STAT_FULL    = 3'd4,
    STAT_IGNORED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK1,
    S_CHK2,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic [21:0] img_len;
    logic [63:0] entry_point;
    logic [63:0] phys_base;
    logic [31:0] window_size;
    logic [63:0] direct_base;
  } cfg_t;

  typedef struct packed {
    logic [31:0] segment_type;
    logic [31:0] segment_flags;
    logic [63:0] file_offset;
    logic [63:0] virt_addr;
    logic [63:0] phys_addr;
    logic [63:0] bytes_in_file;
    logic [63:0] bytes_in_memory;
    logic [63:0] align;
    logic        last;
  } hdr_t;

  typedef struct packed {
    logic        pass;
    logic        entry_hit;
    logic [63:0] seg_end;
  } chk_res_t;

endpackage

@@ design/elf64_segment_validator.sv @@
// elf64_segment_validator.sv: top level, request sequencing, overlap scan and verdict
// a header that is skipped, fails a check or is ignored goes from the checks straight to its result;
// a load header that passes the checks first runs the overlap scan,
// which reads the n stored segments one per cycle from the segment table
// the next request is taken in the cycle after the result is loaded into the output register
// synchronous reset restores the config registers to their defaults and clears the image state
`timescale 1ns / 1ps

module elf64_segment_validator #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [415:0] s_tdata,   // segment_flags, file_offset, virt_addr, phys_addr,
                                  // bytes_in_file, bytes_in_memory, align
  input  logic [31:0]  s_tuser,   // segment_type
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // status, image_ok, segment_count, zero pad
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import elfsv_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  cfg_t       cfg;
  hdr_t       hdr;
  chk_res_t   chk;
  fsm_state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          eie, eie_next;
  logic          err, err_next;
  status_t       status, status_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          cmp_valid, cmp_valid_next;
  logic          overlap, overlap_next;

  logic          rd_en;
  logic [63:0]   rd_start, rd_end;
  logic          fire;
  logic          is_ok;
  logic          err_hit;
  logic [CW-1:0] count_upd;
  logic          eie_upd;
  logic          err_upd;
  logic          scan_done;

  logic [2:0]    out_status;
  logic          out_ok;
  logic [4:0]    out_count;
  logic          out_last;
  logic          m_tvalid_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {7'd0, out_count, out_ok, out_status};
  assign m_tlast   = out_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_len     <= IMG_LEN_RST;
      cfg.entry_point <= ENTRY_POINT_RST;
      cfg.phys_base   <= PHYS_BASE_RST;
      cfg.window_size <= WINDOW_SIZE_RST;
      cfg.direct_base <= DIRECT_BASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMG_LEN:     cfg.img_len     <= cfg_data[21:0];
        CFG_ENTRY_POINT: cfg.entry_point <= cfg_data;
        CFG_PHYS_BASE:   cfg.phys_base   <= cfg_data;
        CFG_WINDOW_SIZE: cfg.window_size <= cfg_data[31:0];
        CFG_DIRECT_BASE: cfg.direct_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hdr.segment_type    <= s_tuser;
      hdr.segment_flags   <= s_tdata[31:0];
      hdr.file_offset     <= s_tdata[95:32];
      hdr.virt_addr       <= s_tdata[159:96];
      hdr.phys_addr       <= s_tdata[223:160];
      hdr.bytes_in_file   <= s_tdata[287:224];
      hdr.bytes_in_memory <= s_tdata[351:288];
      hdr.align           <= s_tdata[415:352];
      hdr.last            <= s_tlast;
    end
  end

  elfsv_check u_check (
    .clk (clk),
    .hdr (hdr),
    .cfg (cfg),
    .res (chk)
  );

  elfsv_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_seg_mem (
    .clk      (clk),
    .wr_en    (fire && is_ok),
    .wr_addr  (count[AW-1:0]),
    .wr_start (hdr.virt_addr),
    .wr_end   (chk.seg_end),
    .rd_en    (rd_en),
    .rd_addr  (rd_idx[AW-1:0]),
    .rd_start (rd_start),
    .rd_end   (rd_end)
  );

  assign fire      = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign is_ok     = (status == STAT_OK);
  assign rd_en     = (state == S_SCAN) && (rd_idx < count);
  assign scan_done = (rd_idx == count) && !cmp_valid;

  always_comb begin
    case (status) inside
      STAT_CHECK, STAT_OVERLAP, STAT_FULL: err_hit = 1'b1;
      default:                             err_hit = 1'b0;
    endcase
  end

  assign count_upd = count + CW'(is_ok);
  assign eie_upd   = eie || (is_ok && chk.entry_hit);
  assign err_upd   = err || err_hit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_CHK1;
      S_CHK1:   state_next = S_CHK2;
      S_CHK2:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (err || hdr.segment_type != PT_LOADABLE || !chk.pass) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN:   if (scan_done) state_next = S_FINISH;
      S_FINISH: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    status_next    = status;
    rd_idx_next    = rd_idx;
    cmp_valid_next = 1'b0;
    overlap_next   = overlap;
    count_next     = count;
    eie_next       = eie;
    err_next       = err;
    unique case (state)
      S_DECIDE: begin
        rd_idx_next  = '0;
        overlap_next = 1'b0;
        if (err) begin
          status_next = STAT_IGNORED;
        end else if (hdr.segment_type != PT_LOADABLE) begin
          status_next = STAT_SKIP;
        end else if (!chk.pass) begin
          status_next = STAT_CHECK;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_idx_next = rd_idx + CW'(1);
        end
        cmp_valid_next = rd_en;
        if (cmp_valid && (hdr.virt_addr < rd_end) && (chk.seg_end > rd_start)) begin
          overlap_next = 1'b1;
        end
        if (scan_done) begin
          if (overlap) begin
            status_next = STAT_OVERLAP;
          end else if (count >= CW'(MAX_SEGMENTS)) begin
            status_next = STAT_FULL;
          end else begin
            status_next = STAT_OK;
          end
        end
      end
      S_FINISH: begin
        if (fire) begin
          if (hdr.last) begin
            count_next = '0;
            eie_next   = 1'b0;
            err_next   = 1'b0;
          end else begin
            count_next = count_upd;
            eie_next   = eie_upd;
            err_next   = err_upd;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (fire) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      eie       <= 1'b0;
      err       <= 1'b0;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      eie       <= eie_next;
      err       <= err_next;
      cmp_valid <= cmp_valid_next;
      m_tvalid  <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    rd_idx  <= rd_idx_next;
    overlap <= overlap_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status;
      out_ok     <= hdr.last && !err_upd && (count_upd != '0) && eie_upd;
      out_count  <= 5'(count_upd);
      out_last   <= hdr.last;
    end
  end

endmodule

@@ design/elfsv_check.sv @@
// elfsv_check.sv: two-stage field checks of one program header
`timescale 1ns / 1ps

module elfsv_check (
  input  logic              clk,
  input  elfsv_pkg::hdr_t   hdr,
  input  elfsv_pkg::cfg_t   cfg,
  output elfsv_pkg::chk_res_t res
);
  import elfsv_pkg::*;

  typedef struct packed {
    logic [63:0] pa_rel;
    logic [63:0] ws_room;
    logic [63:0] map_va;
    logic [63:0] img_room;
    logic [63:0] al_mask;
    logic [63:0] seg_end;
    logic        early_fail;
  } stage1_t;

  stage1_t s1;
  logic [63:0] ws64;
  logic [63:0] isz64;

  assign ws64  = {32'd0, cfg.window_size};
  assign isz64 = {42'd0, cfg.img_len};

  // stage 1: differences, sums and single compares
  always_ff @(posedge clk) begin
    s1.pa_rel     <= hdr.phys_addr - cfg.phys_base;
    s1.ws_room    <= ws64 - hdr.bytes_in_memory;
    s1.map_va     <= cfg.direct_base + hdr.phys_addr;
    s1.img_room   <= isz64 - hdr.file_offset;
    s1.al_mask    <= hdr.align - 64'd1;
    s1.seg_end    <= hdr.virt_addr + hdr.bytes_in_memory;
    s1.early_fail <= (hdr.bytes_in_memory == 64'd0) ||
                     (hdr.bytes_in_file > hdr.bytes_in_memory) ||
                     (hdr.phys_addr < cfg.phys_base) ||
                     (hdr.bytes_in_memory > ws64) ||
                     (hdr.file_offset > isz64) ||
                     (hdr.align == 64'd0) ||
                     (hdr.align > ws64);
  end

  // stage 2: compares against stage 1 results
  always_ff @(posedge clk) begin
    res.pass <= !s1.early_fail &&
                !(s1.pa_rel > s1.ws_room) &&
                (hdr.virt_addr == s1.map_va) &&
                !(hdr.bytes_in_file > s1.img_room) &&
                ((hdr.align & s1.al_mask) == 64'd0) &&
                ((hdr.virt_addr & s1.al_mask) == (hdr.file_offset & s1.al_mask));
    res.entry_hit <= hdr.segment_flags[FLAG_EXEC_BIT] &&
                     (cfg.entry_point >= hdr.virt_addr) &&
                     (cfg.entry_point < s1.seg_end);
    res.seg_end <= s1.seg_end;
  end

endmodule

@@ design/elfsv_seg_mem.sv @@
// elfsv_seg_mem.sv: segment start and end table, one write and one registered read port
`timescale 1ns / 1ps

module elfsv_seg_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_start,
  input  logic [63:0]   wr_end,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_start,
  output logic [63:0]   rd_end
);

  logic [127:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_end, wr_start};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_end, rd_start} <= mem[rd_addr];
    end
  end

endmodule
